>>> design/frustum_cull_test_unit_assert.svh
`ifndef FRUSTUM_CULL_TEST_UNIT_ASSERT_SVH
`define FRUSTUM_CULL_TEST_UNIT_ASSERT_SVH

// A property that must hold at every rising clock edge outside reset.
`define FCULL_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("frustum cull: property violated");

// A condition that must never be true outside reset.
`define FCULL_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("frustum cull: forbidden condition seen");

`endif

>>> design/fcull_pkg.sv
package fcull_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int NUM_PLANES  = 6;
   localparam int COEF_WIDTH  = 16;
   localparam int COEF_FRAC   = 14;
   localparam int PLANE_WIDTH = 4 * COEF_WIDTH;
   localparam int CSR_IDX_W   = $clog2(NUM_PLANES);

   localparam int EXT_W  = COORD_WIDTH + 1;
   localparam int PROD_W = COEF_WIDTH + EXT_W;
   localparam int OFF_W  = ((COORD_WIDTH > COEF_WIDTH) ? COORD_WIDTH : COEF_WIDTH) + 1;
   localparam int ACC_W  = ((PROD_W + 2 > OFF_W + COEF_FRAC) ?
                            PROD_W + 2 : OFF_W + COEF_FRAC) + 1;

   localparam int LATENCY = 1 + 2 * NUM_PLANES;

   typedef enum logic [1:0] {
      CMD_POINT  = 2'd0,
      CMD_SPHERE = 2'd1,
      CMD_CBOX   = 2'd2,
      CMD_MMBOX  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic signed [EXT_W-1:0]       lo_x;
      logic signed [EXT_W-1:0]       hi_x;
      logic signed [EXT_W-1:0]       lo_y;
      logic signed [EXT_W-1:0]       hi_y;
      logic signed [EXT_W-1:0]       lo_z;
      logic signed [EXT_W-1:0]       hi_z;
      logic signed [COORD_WIDTH-1:0] bias;
   } query_type;

   typedef struct packed {
      logic valid;
      logic visible;
   } flow_type;

endpackage

>>> design/fcull_front.sv
module fcull_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    accept,
   input  logic                 [1:0]              cmd,
   input  logic signed [fcull_pkg::COORD_WIDTH-1:0] pos_x,
   input  logic signed [fcull_pkg::COORD_WIDTH-1:0] pos_y,
   input  logic signed [fcull_pkg::COORD_WIDTH-1:0] pos_z,
   input  logic signed [fcull_pkg::COORD_WIDTH-1:0] ext_x,
   input  logic signed [fcull_pkg::COORD_WIDTH-1:0] ext_y,
   input  logic signed [fcull_pkg::COORD_WIDTH-1:0] ext_z,
   output fcull_pkg::flow_type                      flow_out,
   output fcull_pkg::query_type                     q_out
);
   import fcull_pkg::*;

   logic signed [EXT_W-1:0] px, py, pz, ex, ey, ez;
   logic signed [EXT_W-1:0] ax, bx, ay, by, az, bz;
   flow_type  flow_ff, flow_in;
   query_type q_ff, q_in;

   assign px = EXT_W'(pos_x);
   assign py = EXT_W'(pos_y);
   assign pz = EXT_W'(pos_z);
   assign ex = EXT_W'(ext_x);
   assign ey = EXT_W'(ext_y);
   assign ez = EXT_W'(ext_z);

   // The two candidate coordinates per axis; ordering them lets each cell pick
   // the positive vertex from the sign of its coefficient alone.
   always_comb begin
      ax = px;
      bx = px;
      ay = py;
      by = py;
      az = pz;
      bz = pz;
      case (cmd_type'(cmd))
         CMD_CBOX: begin
            ax = px - ex;
            bx = px + ex;
            ay = py - ey;
            by = py + ey;
            az = pz - ez;
            bz = pz + ez;
         end
         CMD_MMBOX: begin
            bx = ex;
            by = ey;
            bz = ez;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      q_in.lo_x = (ax < bx) ? ax : bx;
      q_in.hi_x = (ax < bx) ? bx : ax;
      q_in.lo_y = (ay < by) ? ay : by;
      q_in.hi_y = (ay < by) ? by : ay;
      q_in.lo_z = (az < bz) ? az : bz;
      q_in.hi_z = (az < bz) ? bz : az;
      q_in.bias = (cmd_type'(cmd) == CMD_SPHERE) ? ext_x : '0;
      flow_in.valid   = accept;
      flow_in.visible = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flow_ff <= '0;
      end else begin
         flow_ff <= flow_in;
      end
      q_ff <= q_in;
   end

   assign flow_out = flow_ff;
   assign q_out    = q_ff;

endmodule

>>> design/fcull_cell.sv
module fcull_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 plane_we,
   input  logic [fcull_pkg::PLANE_WIDTH-1:0]    plane_data,
   input  fcull_pkg::flow_type                  flow_in,
   input  fcull_pkg::query_type                 q_in,
   output fcull_pkg::flow_type                  flow_out,
   output fcull_pkg::query_type                 q_out
);
   import fcull_pkg::*;

   `include "frustum_cull_test_unit_assert.svh"

   logic [PLANE_WIDTH-1:0]         plane_ff, plane_in;
   logic signed [COEF_WIDTH-1:0]   coef_a, coef_b, coef_c, coef_d;
   logic signed [EXT_W-1:0]        sel_x, sel_y, sel_z;
   logic signed [PROD_W-1:0]       prod_x_ff, prod_x_in;
   logic signed [PROD_W-1:0]       prod_y_ff, prod_y_in;
   logic signed [PROD_W-1:0]       prod_z_ff, prod_z_in;
   logic signed [OFF_W-1:0]        off_ff, off_in;
   logic signed [ACC_W-1:0]        acc;
   flow_type                       mid_flow_ff, out_flow_ff, out_flow_in;
   query_type                      mid_q_ff, out_q_ff;

   assign plane_in = plane_we ? plane_data : plane_ff;

   assign coef_a = plane_ff[COEF_WIDTH-1:0];
   assign coef_b = plane_ff[2*COEF_WIDTH-1:COEF_WIDTH];
   assign coef_c = plane_ff[3*COEF_WIDTH-1:2*COEF_WIDTH];
   assign coef_d = plane_ff[4*COEF_WIDTH-1:3*COEF_WIDTH];

   // Positive vertex: the larger product takes the maximum for a non-negative
   // coefficient and the minimum otherwise.
   assign sel_x = coef_a[COEF_WIDTH-1] ? q_in.lo_x : q_in.hi_x;
   assign sel_y = coef_b[COEF_WIDTH-1] ? q_in.lo_y : q_in.hi_y;
   assign sel_z = coef_c[COEF_WIDTH-1] ? q_in.lo_z : q_in.hi_z;

   assign prod_x_in = PROD_W'(coef_a) * PROD_W'(sel_x);
   assign prod_y_in = PROD_W'(coef_b) * PROD_W'(sel_y);
   assign prod_z_in = PROD_W'(coef_c) * PROD_W'(sel_z);
   assign off_in    = OFF_W'(coef_d) + OFF_W'(q_in.bias);

   // The sphere radius is folded into the offset, so every query kind is
   // culled by a negative sum.
   assign acc = ACC_W'(prod_x_ff) + ACC_W'(prod_y_ff) + ACC_W'(prod_z_ff)
              + (ACC_W'(off_ff) <<< COEF_FRAC);

   always_comb begin
      out_flow_in.valid   = mid_flow_ff.valid;
      out_flow_in.visible = mid_flow_ff.visible & ~acc[ACC_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff    <= '0;
         mid_flow_ff <= '0;
         out_flow_ff <= '0;
      end else begin
         plane_ff    <= plane_in;
         mid_flow_ff <= flow_in;
         out_flow_ff <= out_flow_in;
      end
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      prod_z_ff <= prod_z_in;
      off_ff    <= off_in;
      mid_q_ff  <= q_in;
      out_q_ff  <= mid_q_ff;
   end

   assign flow_out = out_flow_ff;
   assign q_out    = out_q_ff;

   `FCULL_ASSERT(a_cell_valid_delay, clock, reset,
                 (flow_out.valid == $past(flow_in.valid, 2)))
   `FCULL_NEVER(a_cell_culled_stays, clock, reset,
                ($past(flow_in.valid && !flow_in.visible, 2) && flow_out.visible))

endmodule

>>> design/frustum_cull_test_unit.sv
// Six-plane view-frustum culling test.
// A query is offered on req_cmd and the req_pos_* and req_ext_* ports and is
// taken at a rising edge where start is high and busy is low. busy stays low,
// so a new query may be taken in every cycle.
// The query kinds are a point, a sphere, a box given by centre and half
// extents, and a box given by its minimum and maximum corners.
// The six planes are written through the csr_ port: csr_write_en, an index
// from near to bottom, and the 64-bit packed coefficients. Writes take effect
// at the next edge and should only be made while no query is in flight.
// Each query passes a short front stage and then a row of six plane cells,
// each two stages deep, before its result is shown. Throughput is one query
// per cycle; the latency is set by the front stage and the six cells in
// the row.
// The result is shown on rsp_visible for one cycle while rsp_strobe is high;
// it must be taken in that cycle, as there is no way to hold it back.
// Reset clears all planes to zero, which makes every query visible except a
// sphere with a negative radius, and drops any query in flight.
module frustum_cull_test_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic                 [1:0]              req_cmd,
   input  logic signed [fcull_pkg::COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [fcull_pkg::COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [fcull_pkg::COORD_WIDTH-1:0] req_pos_z,
   input  logic signed [fcull_pkg::COORD_WIDTH-1:0] req_ext_x,
   input  logic signed [fcull_pkg::COORD_WIDTH-1:0] req_ext_y,
   input  logic signed [fcull_pkg::COORD_WIDTH-1:0] req_ext_z,
   output logic                                    rsp_strobe,
   output logic                                    rsp_visible,
   input  logic                                    csr_write_en,
   input  logic [fcull_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [fcull_pkg::PLANE_WIDTH-1:0]        csr_data
);
   import fcull_pkg::*;

   `include "frustum_cull_test_unit_assert.svh"

   logic                  accept;
   logic [NUM_PLANES-1:0] plane_we;
   flow_type              flow_chain [NUM_PLANES+1];
   query_type             q_chain    [NUM_PLANES+1];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   fcull_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .cmd      (req_cmd),
      .pos_x    (req_pos_x),
      .pos_y    (req_pos_y),
      .pos_z    (req_pos_z),
      .ext_x    (req_ext_x),
      .ext_y    (req_ext_y),
      .ext_z    (req_ext_z),
      .flow_out (flow_chain[0]),
      .q_out    (q_chain[0])
   );

   for (genvar k = 0; k < NUM_PLANES; k++) begin : g_cell
      assign plane_we[k] = csr_write_en && (csr_index == CSR_IDX_W'(k));

      fcull_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .plane_we   (plane_we[k]),
         .plane_data (csr_data),
         .flow_in    (flow_chain[k]),
         .q_in       (q_chain[k]),
         .flow_out   (flow_chain[k+1]),
         .q_out      (q_chain[k+1])
      );
   end

   assign rsp_strobe  = flow_chain[NUM_PLANES].valid;
   assign rsp_visible = flow_chain[NUM_PLANES].visible;

   `FCULL_ASSERT(a_accept_gives_result, clock, reset, (accept |-> ##LATENCY rsp_strobe))
   `FCULL_ASSERT(a_result_had_accept, clock, reset, (rsp_strobe |-> $past(accept, LATENCY)))

endmodule
